// ----- design/mqsb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqsb_pkg
// Shared constants and types of the multi-queue shared buffer.
// ----------------------------------------------------------------------------
package mqsb_pkg;

    // store geometry
    localparam int ENTRIES = 16;
    localparam int QUEUES  = 4;

    // link index carries one extra code for the null link
    localparam int IDX_W  = $clog2(ENTRIES + 1);
    localparam int ENT_AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IDX_W-1:0] NIL_LINK = IDX_W'(ENTRIES);

    // payload widths
    localparam int DATA_W = 32;
    localparam int QID_W  = 2;

    typedef enum logic {
        CMD_ENQ = 1'b0,
        CMD_DEQ = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    // one result beat between the core and the output stage
    typedef struct packed {
        logic signed [DATA_W-1:0] data_out;
        status_t                  status;
    } rsp_t;

endpackage

// ----- design/mqsb_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqsb_req_if
// Command channel: enqueue or dequeue beats with queue number and word.
// ----------------------------------------------------------------------------
interface mqsb_req_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 command;
    logic [mqsb_pkg::QID_W-1:0]           queue_id;
    logic signed [mqsb_pkg::DATA_W-1:0]   data_in;

    modport source (output valid, output command, output queue_id, output data_in,
                    input ready);
    modport sink   (input valid, input command, input queue_id, input data_in,
                    output ready);
endinterface

// ----- design/mqsb_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqsb_rsp_if
// Result channel: dequeued word and status per command.
// ----------------------------------------------------------------------------
interface mqsb_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [mqsb_pkg::DATA_W-1:0]   data_out;
    logic [1:0]                           status;

    modport source (output valid, output data_out, output status, input ready);
    modport sink   (input valid, input data_out, input status, output ready);
endinterface

// ----- design/mqsb_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqsb_core
// Linked-list queue state: entry words, links, head/tail per queue and the
// free list, updated for each accepted command that succeeds.
// ----------------------------------------------------------------------------
module mqsb_core
(
    input  logic                clk,
    input  logic                rst_n,
    mqsb_req_if.sink            req,
    input  logic                rsp_ready,
    output logic                rsp_push,
    output mqsb_pkg::rsp_t      rsp_beat
);

    // state
    logic signed [mqsb_pkg::DATA_W-1:0] entry_mem [mqsb_pkg::ENTRIES];
    logic [mqsb_pkg::IDX_W-1:0] link_reg [mqsb_pkg::ENTRIES];
    logic [mqsb_pkg::IDX_W-1:0] head_reg [mqsb_pkg::QUEUES];
    logic [mqsb_pkg::IDX_W-1:0] tail_reg [mqsb_pkg::QUEUES];
    logic [mqsb_pkg::IDX_W-1:0] free_head_reg;
    logic [mqsb_pkg::IDX_W-1:0] free_head_next;

    // decode
    logic                       accept;
    logic                       q_ok;
    logic                       free_ok;
    logic                       head_ok;
    logic                       tail_ok;
    logic [mqsb_pkg::IDX_W-1:0] cur_head;
    logic [mqsb_pkg::IDX_W-1:0] cur_tail;
    logic                       enq_ok;
    logic                       deq_ok;
    logic [mqsb_pkg::IDX_W-1:0] link_rd_addr;
    logic [mqsb_pkg::IDX_W-1:0] link_rd;

    // write controls
    logic                       head_wr;
    logic [mqsb_pkg::IDX_W-1:0] head_wr_val;
    logic                       tail_wr;
    logic                       link_wr;
    logic [mqsb_pkg::IDX_W-1:0] link_wr_addr;
    logic [mqsb_pkg::IDX_W-1:0] link_wr_val;
    logic                       free_wr;

    assign req.ready = rsp_ready;
    assign accept    = req.valid && req.ready;

    // queue lookup, out-of-range queues read as empty
    assign q_ok     = (int'(req.queue_id) < mqsb_pkg::QUEUES);
    assign cur_head = q_ok ? head_reg[req.queue_id] : mqsb_pkg::NIL_LINK;
    assign cur_tail = q_ok ? tail_reg[req.queue_id] : mqsb_pkg::NIL_LINK;
    assign free_ok  = (free_head_reg < mqsb_pkg::NIL_LINK);
    assign head_ok  = (cur_head < mqsb_pkg::NIL_LINK);
    assign tail_ok  = (cur_tail < mqsb_pkg::NIL_LINK);

    assign enq_ok = (req.command == mqsb_pkg::CMD_ENQ) && q_ok && free_ok;
    assign deq_ok = (req.command == mqsb_pkg::CMD_DEQ) && q_ok && head_ok;

    // single link read: free-list successor or queue successor
    assign link_rd_addr = (req.command == mqsb_pkg::CMD_ENQ) ? free_head_reg : cur_head;
    assign link_rd      = link_reg[link_rd_addr[mqsb_pkg::ENT_AW-1:0]];

    // next-state controls; the tail's own link is never trusted, a dequeue of
    // the tail entry empties the queue instead
    always_comb
    begin
        head_wr        = 1'b0;
        head_wr_val    = free_head_reg;
        tail_wr        = 1'b0;
        link_wr        = 1'b0;
        link_wr_addr   = cur_tail;
        link_wr_val    = free_head_reg;
        free_wr        = 1'b0;
        free_head_next = link_rd;
        if (accept && enq_ok)
        begin
            free_wr = 1'b1;
            tail_wr = 1'b1;
            if (!head_ok)
            begin
                head_wr = 1'b1;
            end
            else if (tail_ok)
            begin
                link_wr = 1'b1;
            end
        end
        else if (accept && deq_ok)
        begin
            free_wr        = 1'b1;
            free_head_next = cur_head;
            head_wr        = 1'b1;
            head_wr_val    = (cur_head == cur_tail) ? mqsb_pkg::NIL_LINK : link_rd;
            link_wr        = 1'b1;
            link_wr_addr   = cur_head;
        end
    end

    // pointer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < mqsb_pkg::ENTRIES; i++)
            begin
                link_reg[i] <= mqsb_pkg::IDX_W'(i + 1);
            end
            for (int j = 0; j < mqsb_pkg::QUEUES; j++)
            begin
                head_reg[j] <= mqsb_pkg::NIL_LINK;
                tail_reg[j] <= mqsb_pkg::NIL_LINK;
            end
            free_head_reg <= '0;
        end
        else
        begin
            if (free_wr)
            begin
                free_head_reg <= free_head_next;
            end
            if (head_wr)
            begin
                head_reg[req.queue_id] <= head_wr_val;
            end
            if (tail_wr)
            begin
                tail_reg[req.queue_id] <= free_head_reg;
            end
            if (link_wr)
            begin
                link_reg[link_wr_addr[mqsb_pkg::ENT_AW-1:0]] <= link_wr_val;
            end
        end
    end

    // entry words, written on a successful enqueue
    always_ff @(posedge clk)
    begin
        if (accept && enq_ok)
        begin
            entry_mem[free_head_reg[mqsb_pkg::ENT_AW-1:0]] <= req.data_in;
        end
    end

    // result beat
    always_comb
    begin
        rsp_push          = accept;
        rsp_beat.data_out = '0;
        rsp_beat.status   = mqsb_pkg::STATUS_OK;
        if (req.command == mqsb_pkg::CMD_ENQ)
        begin
            if (!enq_ok)
            begin
                rsp_beat.status = mqsb_pkg::STATUS_FULL;
            end
        end
        else if (deq_ok)
        begin
            rsp_beat.data_out = entry_mem[cur_head[mqsb_pkg::ENT_AW-1:0]];
        end
        else
        begin
            rsp_beat.status = mqsb_pkg::STATUS_EMPTY;
        end
    end

endmodule

// ----- design/mqsb_out_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqsb_out_stage
// Result register with a skid slot, so commands keep flowing while one
// result waits on the sink.
// ----------------------------------------------------------------------------
module mqsb_out_stage
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  mqsb_pkg::rsp_t      push_beat,
    output logic                push_ready,
    mqsb_rsp_if.source          rsp
);

    logic           main_valid_reg;
    logic           skid_valid_reg;
    mqsb_pkg::rsp_t main_reg;
    mqsb_pkg::rsp_t skid_reg;
    logic           pop;

    assign pop        = main_valid_reg && rsp.ready;
    assign push_ready = !skid_valid_reg;

    assign rsp.valid    = main_valid_reg;
    assign rsp.data_out = main_reg.data_out;
    assign rsp.status   = main_reg.status;

    // occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (main_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                main_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            main_valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_reg <= skid_reg;
            end
        end
        else if (push)
        begin
            if (main_valid_reg && !pop)
            begin
                skid_reg <= push_beat;
            end
            else
            begin
                main_reg <= push_beat;
            end
        end
    end

endmodule

// ----- design/multi_queue_shared_buffer_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_queue_shared_buffer_top
// Several FIFO queues sharing one linked entry store with a free list.
// ----------------------------------------------------------------------------
//  channel | dir | beat contents
//  --------+-----+-----------------------------------------
//  req     | in  | command, queue_id, data_in
//  rsp     | out | data_out, status (one per req beat)
//
//  one command per cycle while req.ready is high; the result is registered
//  pointers update on acceptance: one link read, at most one link write
//  reset sets the free chain and empty queues at once, no clearing pass
//  req.ready drops only when both the result register and skid slot are full
// ----------------------------------------------------------------------------
module multi_queue_shared_buffer_top
(
    input  logic        clk,
    input  logic        rst_n,
    mqsb_req_if.sink    req,
    mqsb_rsp_if.source  rsp
);

    logic           rsp_push;
    logic           rsp_ready;
    mqsb_pkg::rsp_t rsp_beat;

    // queue state and command decode
    mqsb_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp_ready (rsp_ready),
        .rsp_push  (rsp_push),
        .rsp_beat  (rsp_beat)
    );

    // result register and skid slot
    mqsb_out_stage u_out
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (rsp_push),
        .push_beat  (rsp_beat),
        .push_ready (rsp_ready),
        .rsp        (rsp)
    );

endmodule

// ----- design/mqsb_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqsb_checker
// Port-level checks of the multi-queue shared buffer, bound to the top.
// ----------------------------------------------------------------------------
module mqsb_checker
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               req_valid,
    input  logic                               req_ready,
    input  logic                               rsp_valid,
    input  logic                               rsp_ready,
    input  logic signed [mqsb_pkg::DATA_W-1:0] rsp_data_out,
    input  logic [1:0]                         rsp_status
);

    // every accepted command leaves a result waiting in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> rsp_valid)
    else $error("no result after accepted command");

    // failed commands return a zero word
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status != mqsb_pkg::STATUS_OK) |-> rsp_data_out == '0)
    else $error("nonzero word on failed command");

    // status stays within its three codes
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_status == mqsb_pkg::STATUS_OK) ||
                      (rsp_status == mqsb_pkg::STATUS_FULL) ||
                      (rsp_status == mqsb_pkg::STATUS_EMPTY))
    else $error("bad status code");

    // stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data_out) && $stable(rsp_status))
    else $error("result changed under stall");

endmodule

bind multi_queue_shared_buffer_top mqsb_checker u_mqsb_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .rsp_data_out (rsp.data_out),
    .rsp_status   (rsp.status)
);
